// ===== rtl/pqu_pkg.sv =====
`timescale 1ns / 1ps

package pqu_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int ID_BITS     = 16;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    ACT_INSERT = 2'd0,
    ACT_POP    = 2'd1,
    ACT_REMOVE = 2'd2,
    ACT_CLEAR  = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_DISABLED = 2'd2,
    ST_FULL     = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    MODE_INSERT,
    MODE_POP,
    MODE_REMOVE,
    MODE_HOLD
  } cell_mode_t;

  typedef struct packed {
    logic       step;
    cell_mode_t mode;
  } cell_ctrl_t;

  typedef struct packed {
    logic signed [7:0]   prio;
    logic [ID_BITS-1:0]  id;
    logic [15:0]         tag;
  } entry_t;

  typedef struct packed {
    action_t            action;
    logic signed [7:0]  priority_req;
    logic [15:0]        entry_id;
    logic [15:0]        payload_tag;
  } cmd_t;

  typedef struct packed {
    status_t            status;
    logic signed [7:0]  out_priority;
    logic [15:0]        out_id;
    logic [15:0]        out_tag;
    logic [4:0]         occupancy;
    logic               queue_empty;
  } rsp_t;

endpackage

// ===== rtl/priority_ordered_queue_unit.sv =====
`timescale 1ns / 1ps

// Channel | Dir | Handshake              | Payload
// cmd     | in  | cmd_valid / cmd_ready  | cmd (cmd_t)
// rsp     | out | rsp_valid / rsp_ready  | rsp (rsp_t)
// cfg     | in  | cfg_valid / cfg_ready  | cfg_enable (queue enable)
//
// Each command is first captured into a register; insert and pop then shift the
// row of slot cells once, and clear only resets the count. Remove-by-id shifts
// the row once per matching entry, since the row drops one match per shift.
// Reset empties the queue and sets the enable; slot contents are not cleared.
// A held response stalls the next command only at its execute cycle.

module priority_ordered_queue_unit
  import pqu_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic cmd_valid,
  output logic cmd_ready,
  input  cmd_t cmd,
  output logic rsp_valid,
  input  logic rsp_ready,
  output rsp_t rsp,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic cfg_enable
);

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  state_t           state;
  cmd_t             cmd_reg;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic             queue_enable;

  cell_ctrl_t       ctrl;
  entry_t           new_entry;
  entry_t           cell_entry [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] take_vec;
  logic [QUEUE_DEPTH-1:0] hole_vec;

  logic             done;
  logic             rsp_free;
  rsp_t             rsp_next;

  assign cfg_ready = 1'b1;
  assign cmd_ready = (state == S_IDLE);
  assign rsp_free  = !rsp_valid || rsp_ready;

  assign new_entry.prio = cmd_reg.priority_req;
  assign new_entry.id   = ID_BITS'(cmd_reg.entry_id);
  assign new_entry.tag  = cmd_reg.payload_tag;

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic   occ;
    entry_t left_e;
    entry_t right_e;
    logic   take_l;
    logic   hole_l;

    assign occ = (CNT_W'(i) < count);

    if (i == 0) begin : g_first
      assign left_e = new_entry;
      assign take_l = 1'b0;
      assign hole_l = 1'b0;
    end else begin : g_mid
      assign left_e = cell_entry[i-1];
      assign take_l = take_vec[i-1];
      assign hole_l = hole_vec[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_last
      assign right_e = cell_entry[i];
    end else begin : g_inner
      assign right_e = cell_entry[i+1];
    end

    pqu_cell u_cell (
      .clk         (clk),
      .ctrl        (ctrl),
      .new_entry   (new_entry),
      .occupied    (occ),
      .left_entry  (left_e),
      .right_entry (right_e),
      .take_left   (take_l),
      .hole_left   (hole_l),
      .entry       (cell_entry[i]),
      .take        (take_vec[i]),
      .hole        (hole_vec[i])
    );
  end

  always_comb begin
    ctrl.step    = 1'b0;
    ctrl.mode    = MODE_HOLD;
    count_next   = count;
    done         = 1'b0;
    rsp_next     = '0;
    rsp_next.status = ST_OK;
    if (state == S_EXEC && rsp_free) begin
      case (cmd_reg.action)
        ACT_INSERT: begin
          done = 1'b1;
          if (!queue_enable) begin
            rsp_next.status = ST_DISABLED;
          end else if (count == CNT_W'(QUEUE_DEPTH)) begin
            rsp_next.status = ST_FULL;
          end else begin
            ctrl.step  = 1'b1;
            ctrl.mode  = MODE_INSERT;
            count_next = count + 1'b1;
          end
        end
        ACT_POP: begin
          done = 1'b1;
          if (!queue_enable) begin
            rsp_next.status = ST_DISABLED;
          end else if (count == '0) begin
            rsp_next.status = ST_EMPTY;
          end else begin
            ctrl.step             = 1'b1;
            ctrl.mode             = MODE_POP;
            count_next            = count - 1'b1;
            rsp_next.out_priority = cell_entry[0].prio;
            rsp_next.out_id       = 16'(cell_entry[0].id);
            rsp_next.out_tag      = cell_entry[0].tag;
          end
        end
        ACT_REMOVE: begin
          // The last cell's hole flag says whether any occupied slot matches.
          if (hole_vec[QUEUE_DEPTH-1]) begin
            ctrl.step  = 1'b1;
            ctrl.mode  = MODE_REMOVE;
            count_next = count - 1'b1;
          end else begin
            done = 1'b1;
          end
        end
        default: begin
          done       = 1'b1;
          count_next = '0;
        end
      endcase
    end
    rsp_next.occupancy   = 5'(count_next);
    rsp_next.queue_empty = (count_next == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      count        <= '0;
      queue_enable <= 1'b1;
      rsp_valid    <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        queue_enable <= cfg_enable;
      end
      count <= count_next;
      // A new response can only be loaded once the held one is free to go.
      if (done) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (cmd_valid) begin
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (done) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_valid && cmd_ready) begin
      cmd_reg <= cmd;
    end
    if (done) begin
      rsp <= rsp_next;
    end
  end

endmodule

// ===== rtl/pqu_cell.sv =====
`timescale 1ns / 1ps

module pqu_cell
  import pqu_pkg::*;
(
  input  logic       clk,
  input  cell_ctrl_t ctrl,
  input  entry_t     new_entry,
  input  logic       occupied,
  input  entry_t     left_entry,
  input  entry_t     right_entry,
  input  logic       take_left,
  input  logic       hole_left,
  output entry_t     entry,
  output logic       take,
  output logic       hole
);

  // An empty slot always takes; among occupied slots the order is descending,
  // so take is monotone along the row and the first taker is the insert point.
  assign take = !occupied || ($signed(new_entry.prio) > $signed(entry.prio));

  // Once a matching slot is seen, every slot from there on moves left by one.
  assign hole = hole_left || (occupied && (entry.id == new_entry.id));

  always_ff @(posedge clk) begin
    if (ctrl.step) begin
      case (ctrl.mode)
        MODE_INSERT: begin
          if (take_left) begin
            entry <= left_entry;
          end else if (take) begin
            entry <= new_entry;
          end
        end
        MODE_POP: begin
          entry <= right_entry;
        end
        MODE_REMOVE: begin
          if (hole) begin
            entry <= right_entry;
          end
        end
        default: begin
          entry <= entry;
        end
      endcase
    end
  end

endmodule

// ===== tb/priority_ordered_queue_unit_tb.sv =====
`timescale 1ns / 1ps

module priority_ordered_queue_unit_tb;
  import pqu_pkg::*;

  typedef enum {MIX_FILL, MIX_DRAIN, MIX_EVEN} mix_t;

  // Tracks the queue contents and the enable, and holds the responses still owed.
  class queue_checker;
    entry_t held [QUEUE_DEPTH];
    int     held_cnt;
    bit     enabled;
    rsp_t   expected_rsp [$];
    int     errors;

    function new();
      held_cnt = 0;
      enabled  = 1'b1;
      errors   = 0;
    endfunction

    function rsp_t predict_rsp(cmd_t c);
      rsp_t r;
      int   pos;
      int   keep;
      r = '0;
      r.status = ST_OK;
      case (c.action)
        ACT_INSERT: begin
          if (!enabled) begin
            r.status = ST_DISABLED;
          end else if (held_cnt >= QUEUE_DEPTH) begin
            r.status = ST_FULL;
          end else begin
            // Ties keep arrival order: the new entry goes behind equal priorities.
            pos = held_cnt;
            for (int i = 0; i < held_cnt; i++) begin
              if (pos == held_cnt && $signed(c.priority_req) > $signed(held[i].prio)) begin
                pos = i;
              end
            end
            for (int i = held_cnt; i > pos; i--) held[i] = held[i-1];
            held[pos].prio = c.priority_req;
            held[pos].id   = c.entry_id[ID_BITS-1:0];
            held[pos].tag  = c.payload_tag;
            held_cnt++;
          end
        end
        ACT_POP: begin
          if (!enabled) begin
            r.status = ST_DISABLED;
          end else if (held_cnt == 0) begin
            r.status = ST_EMPTY;
          end else begin
            r.out_priority = held[0].prio;
            r.out_id       = held[0].id;
            r.out_tag      = held[0].tag;
            for (int i = 1; i < held_cnt; i++) held[i-1] = held[i];
            held_cnt--;
          end
        end
        ACT_REMOVE: begin
          keep = 0;
          for (int i = 0; i < held_cnt; i++) begin
            if (held[i].id != c.entry_id[ID_BITS-1:0]) begin
              held[keep] = held[i];
              keep++;
            end
          end
          held_cnt = keep;
        end
        default: begin
          held_cnt = 0;
        end
      endcase
      r.occupancy   = 5'(held_cnt);
      r.queue_empty = (held_cnt == 0);
      return r;
    endfunction

    function void note_cmd(cmd_t c);
      expected_rsp.insert(expected_rsp.size(), predict_rsp(c));
    endfunction

    function void check_rsp(rsp_t got);
      rsp_t want;
      if (expected_rsp.size() == 0) begin
        $error("response with nothing outstanding: status %0d", got.status);
        errors++;
        return;
      end
      want = expected_rsp.pop_front();
      if (got.status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, got.status);
        errors++;
      end
      if (got.out_priority !== want.out_priority) begin
        $error("out_priority: expected %0d, got %0d",
               $signed(want.out_priority), $signed(got.out_priority));
        errors++;
      end
      if (got.out_id !== want.out_id) begin
        $error("out_id: expected %0h, got %0h", want.out_id, got.out_id);
        errors++;
      end
      if (got.out_tag !== want.out_tag) begin
        $error("out_tag: expected %0h, got %0h", want.out_tag, got.out_tag);
        errors++;
      end
      if (got.occupancy !== want.occupancy) begin
        $error("occupancy: expected %0d, got %0d", want.occupancy, got.occupancy);
        errors++;
      end
      if (got.queue_empty !== want.queue_empty) begin
        $error("queue_empty: expected %0b, got %0b", want.queue_empty, got.queue_empty);
        errors++;
      end
    endfunction

    function int pending();
      return expected_rsp.size();
    endfunction
  endclass

  logic clk        = 1'b0;
  logic rst        = 1'b1;
  logic cmd_valid  = 1'b0;
  logic cmd_ready;
  cmd_t cmd        = '0;
  logic rsp_valid;
  logic rsp_ready  = 1'b0;
  rsp_t rsp;
  logic cfg_valid  = 1'b0;
  logic cfg_ready;
  logic cfg_enable = 1'b1;

  queue_checker tracker = new();

  int burst_left = 0;
  int ready_mode = 0;
  int mode_left  = 0;
  logic [1:0] stripe_cnt = '0;

  logic [7:0]  dir_prio [17] = '{8'h00, 8'h00, 8'h7F, 8'h80, 8'h05, 8'h05, 8'hFF, 8'h7F,
                                 8'h80, 8'h01, 8'hFE, 8'h40, 8'hC0, 8'h03, 8'h03, 8'h00,
                                 8'h64};
  logic [15:0] dir_id [17]   = '{16'h0001, 16'h0002, 16'hFFFF, 16'h0000, 16'h0003, 16'h0003,
                                 16'h0003, 16'h0007, 16'h0007, 16'h8000, 16'h00FF, 16'h0003,
                                 16'h0009, 16'h000A, 16'h000B, 16'h000C, 16'h000D};

  mix_t phase_mix [6] = '{MIX_FILL, MIX_DRAIN, MIX_EVEN, MIX_EVEN, MIX_FILL, MIX_EVEN};
  bit   phase_en  [6] = '{1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1};
  int   phase_len [6] = '{110, 90, 40, 120, 30, 130};

  priority_ordered_queue_unit u_top (
    .clk        (clk),
    .rst        (rst),
    .cmd_valid  (cmd_valid),
    .cmd_ready  (cmd_ready),
    .cmd        (cmd),
    .rsp_valid  (rsp_valid),
    .rsp_ready  (rsp_ready),
    .rsp        (rsp),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_enable (cfg_enable)
  );

  always #5 clk = ~clk;

  // The response side switches between stall patterns at random times.
  always @(posedge clk) begin
    stripe_cnt <= stripe_cnt + 2'd1;
    if (mode_left == 0) begin
      ready_mode <= $urandom_range(0, 3);
      mode_left  <= $urandom_range(20, 120);
    end else begin
      mode_left <= mode_left - 1;
    end
    case (ready_mode)
      0:       rsp_ready <= 1'b1;
      1:       rsp_ready <= 1'($urandom_range(0, 1));
      2:       rsp_ready <= (stripe_cnt == 2'd0);
      default: rsp_ready <= ($urandom_range(0, 15) == 0);
    endcase
  end

  // A response can never belong to the item accepted at the same edge.
  always @(posedge clk) begin
    if (!rst) begin
      if (rsp_valid && rsp_ready) tracker.check_rsp(rsp);
      if (cmd_valid && cmd_ready) tracker.note_cmd(cmd);
    end
  end

  function automatic cmd_t make_cmd(action_t a, logic [7:0] p, logic [15:0] id,
                                    logic [15:0] tag);
    cmd_t c;
    c.action       = a;
    c.priority_req = p;
    c.entry_id     = id;
    c.payload_tag  = tag;
    return c;
  endfunction

  function automatic cmd_t random_cmd(mix_t mix);
    cmd_t c;
    int   roll;
    int   ins_lim;
    int   pop_lim;
    int   rem_lim;
    case (mix)
      MIX_FILL:  begin ins_lim = 70; pop_lim = 88; rem_lim = 99; end
      MIX_DRAIN: begin ins_lim = 35; pop_lim = 80; rem_lim = 95; end
      default:   begin ins_lim = 50; pop_lim = 80; rem_lim = 94; end
    endcase
    roll = $urandom_range(0, 99);
    if (roll < ins_lim)      c.action = ACT_INSERT;
    else if (roll < pop_lim) c.action = ACT_POP;
    else if (roll < rem_lim) c.action = ACT_REMOVE;
    else                     c.action = ACT_CLEAR;
    // Mostly a narrow band of priorities so that ties are common.
    case ($urandom_range(0, 3))
      0, 1:    c.priority_req = 8'($urandom_range(0, 4) - 2);
      2:       c.priority_req = 8'($urandom);
      default: c.priority_req = $urandom_range(0, 1) ? 8'h7F : 8'h80;
    endcase
    // A small id pool lets remove-by-id hit several entries at once.
    c.entry_id    = ($urandom_range(0, 9) < 7) ? 16'($urandom_range(0, 5)) : 16'($urandom);
    c.payload_tag = 16'($urandom);
    return c;
  endfunction

  task automatic send_cmd(input cmd_t c);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        cmd_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 30);
    end
    burst_left--;
    cmd       <= c;
    cmd_valid <= 1'b1;
    do @(posedge clk); while (!cmd_ready);
  endtask

  task automatic settle();
    cmd_valid <= 1'b0;
    burst_left = 0;
    @(negedge clk);
    while (tracker.pending() != 0) @(negedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_enable(input bit value);
    settle();
    cfg_enable <= value;
    cfg_valid  <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    tracker.enabled = value;
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    write_enable(1'b1);

    send_cmd(make_cmd(ACT_POP, 8'h00, 16'h0000, 16'h0000));
    // Seventeen inserts: the last one finds the queue full.
    for (int i = 0; i < 17; i++) begin
      send_cmd(make_cmd(ACT_INSERT, dir_prio[i], dir_id[i],
                        (i == 0) ? 16'h0000 : (i == 1) ? 16'hFFFF : 16'h5A00 + 16'(i)));
    end
    send_cmd(make_cmd(ACT_POP, 8'h00, 16'h0000, 16'h0000));
    send_cmd(make_cmd(ACT_REMOVE, 8'h00, 16'h0003, 16'h0000));
    send_cmd(make_cmd(ACT_REMOVE, 8'h00, 16'h1234, 16'h0000));

    write_enable(1'b0);
    send_cmd(make_cmd(ACT_INSERT, 8'h7F, 16'h0004, 16'hBEEF));
    send_cmd(make_cmd(ACT_POP, 8'h00, 16'h0000, 16'h0000));
    send_cmd(make_cmd(ACT_REMOVE, 8'h00, 16'h0007, 16'h0000));
    send_cmd(make_cmd(ACT_CLEAR, 8'h00, 16'h0000, 16'h0000));

    for (int p = 0; p < 6; p++) begin
      write_enable(phase_en[p]);
      for (int n = 0; n < phase_len[p]; n++) send_cmd(random_cmd(phase_mix[p]));
    end

    settle();
    repeat (20) @(posedge clk);
    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/pqu_pkg.sv
rtl/pqu_cell.sv
rtl/priority_ordered_queue_unit.sv
tb/priority_ordered_queue_unit_tb.sv
